>>> hdl/ngq_pkg.sv
`default_nettype none
package ngq_pkg;

  localparam int GRID_BITS = 16;
  localparam int PCT_BITS  = 7;
  localparam int ADDR_BITS = 5;

  // register indexes on the configuration port
  localparam logic [2:0] REG_GRID    = 3'd0;
  localparam logic [2:0] REG_FIXED   = 3'd1;
  localparam logic [2:0] REG_PERCENT = 3'd2;
  localparam logic [2:0] REG_QUANT   = 3'd3;
  localparam logic [2:0] REG_CAPTURE = 3'd4;
  localparam logic [2:0] REG_START   = 3'd5;
  localparam logic [2:0] REG_END     = 3'd6;
  localparam logic [2:0] REG_FIXEN   = 3'd7;

  // settings seen by the post-division stages
  typedef struct packed {
    logic [GRID_BITS-1:0] grid;    // effective grid, never zero
    logic [GRID_BITS-1:0] fixed_len;
    logic [GRID_BITS-1:0] win;     // capture window in ticks
    logic                 quant;
    logic                 capture;
    logic                 start_en;
    logic                 end_en;
    logic                 fixed_en;
  } ngq_cfg_t;

endpackage
`default_nettype wire

>>> hdl/note_grid_quantizer.sv
// note grid quantizer: snaps note start/end ticks to a grid
// an accepted note runs through the divider stages, then snap stages a, b and c, to the done strobe
// throughput: one note per cycle; busy is always low
// the snap follows from the remainder divider, one dividend bit per stage
// the receiver cannot stall: each result shows for exactly one cycle
// reset: synchronous active-high rst clears valid bits and restores registers
`default_nettype none
module note_grid_quantizer #(
  parameter int TICK_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // apb configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ngq_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // note input
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [TICK_BITS-1:0]          recorded_start,
  input  wire logic [TICK_BITS-1:0]          recorded_end,
  input  wire logic [TICK_BITS-1:0]          current_start,
  input  wire logic [TICK_BITS-1:0]          current_end,
  input  wire logic                          listed,
  // result
  output logic                               done,
  output logic [TICK_BITS:0]                 new_start,
  output logic [TICK_BITS:0]                 new_end,
  output logic                               moved
);
  import ngq_pkg::*;

  localparam int LATENCY = TICK_BITS + 3;
  // floor(y/25) as (y*RECIP)>>RECIP_SHIFT, exact for y below 2^20
  localparam logic [20:0] RECIP       = 21'd1342178;
  localparam int          RECIP_SHIFT = 25;
  localparam logic [6:0]  PCT_MAX     = 7'd100;

  // configuration registers
  logic [GRID_BITS-1:0] grid_ticks;
  logic [GRID_BITS-1:0] fixed_length_ticks;
  logic [PCT_BITS-1:0]  capture_percent;
  logic                 quantize_enable;
  logic                 capture_enable;
  logic                 start_enable;
  logic                 end_enable;
  logic                 fixed_length_enable;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_ticks          <= 16'd240;
      fixed_length_ticks  <= 16'd240;
      capture_percent     <= 7'd100;
      quantize_enable     <= 1'b0;
      capture_enable      <= 1'b0;
      start_enable        <= 1'b1;
      end_enable          <= 1'b0;
      fixed_length_enable <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRID:    grid_ticks          <= pwdata[GRID_BITS-1:0];
        REG_FIXED:   fixed_length_ticks  <= pwdata[GRID_BITS-1:0];
        REG_PERCENT: capture_percent     <= pwdata[PCT_BITS-1:0];
        REG_QUANT:   quantize_enable     <= pwdata[0];
        REG_CAPTURE: capture_enable      <= pwdata[0];
        REG_START:   start_enable        <= pwdata[0];
        REG_END:     end_enable          <= pwdata[0];
        REG_FIXEN:   fixed_length_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_GRID:    prdata = {16'd0, grid_ticks};
      REG_FIXED:   prdata = {16'd0, fixed_length_ticks};
      REG_PERCENT: prdata = {25'd0, capture_percent};
      REG_QUANT:   prdata = {31'd0, quantize_enable};
      REG_CAPTURE: prdata = {31'd0, capture_enable};
      REG_START:   prdata = {31'd0, start_enable};
      REG_END:     prdata = {31'd0, end_enable};
      REG_FIXEN:   prdata = {31'd0, fixed_length_enable};
      default:     prdata = '0;
    endcase
  end

  // zero grid acts as one
  logic [GRID_BITS-1:0] grid_eff;
  assign grid_eff = (grid_ticks == '0) ? GRID_BITS'(1) : grid_ticks;

  // capture window: (grid*pct + 100) / 200, two registered steps;
  // only the post-division stages read it
  logic [PCT_BITS-1:0] pct_sat;
  logic [22:0]         win_sum;
  logic [40:0]         win_prod;
  logic [GRID_BITS-1:0] win;

  assign pct_sat  = (capture_percent > PCT_MAX) ? PCT_MAX : capture_percent;
  assign win_prod = 41'(win_sum[22:3]) * 41'(RECIP);

  always_ff @(posedge clk) begin
    win_sum <= 23'(grid_eff) * 23'(pct_sat) + 23'd100;
    win     <= GRID_BITS'(win_prod >> RECIP_SHIFT);
  end

  ngq_cfg_t cfg;
  always_comb begin
    cfg.grid      = grid_eff;
    cfg.fixed_len = fixed_length_ticks;
    cfg.win       = win;
    cfg.quant     = quantize_enable;
    cfg.capture   = capture_enable;
    cfg.start_en  = start_enable;
    cfg.end_en    = end_enable;
    cfg.fixed_en  = fixed_length_enable;
  end

  // remainder divider chain, msb first, both tick lanes side by side
  logic                 c_vld    [0:TICK_BITS];
  logic [TICK_BITS-1:0] c_rs     [0:TICK_BITS];
  logic [TICK_BITS-1:0] c_re     [0:TICK_BITS];
  logic [TICK_BITS-1:0] c_cs     [0:TICK_BITS];
  logic [TICK_BITS-1:0] c_ce     [0:TICK_BITS];
  logic                 c_listed [0:TICK_BITS];
  logic [GRID_BITS-1:0] c_rem_s  [0:TICK_BITS];
  logic [GRID_BITS-1:0] c_rem_e  [0:TICK_BITS];

  assign c_vld[0]    = start;
  assign c_rs[0]     = recorded_start;
  assign c_re[0]     = recorded_end;
  assign c_cs[0]     = current_start;
  assign c_ce[0]     = current_end;
  assign c_listed[0] = listed;
  assign c_rem_s[0]  = '0;
  assign c_rem_e[0]  = '0;

  for (genvar k = 0; k < TICK_BITS; k++) begin : g_div
    ngq_div_stage #(
      .TICK_BITS (TICK_BITS),
      .BIT_POS   (TICK_BITS - 1 - k)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .grid       (grid_eff),
      .in_vld     (c_vld[k]),
      .in_rs      (c_rs[k]),
      .in_re      (c_re[k]),
      .in_cs      (c_cs[k]),
      .in_ce      (c_ce[k]),
      .in_listed  (c_listed[k]),
      .in_rem_s   (c_rem_s[k]),
      .in_rem_e   (c_rem_e[k]),
      .out_vld    (c_vld[k+1]),
      .out_rs     (c_rs[k+1]),
      .out_re     (c_re[k+1]),
      .out_cs     (c_cs[k+1]),
      .out_ce     (c_ce[k+1]),
      .out_listed (c_listed[k+1]),
      .out_rem_s  (c_rem_s[k+1]),
      .out_rem_e  (c_rem_e[k+1])
    );
  end

  // snap, end rules and move decision
  ngq_snap #(
    .TICK_BITS (TICK_BITS)
  ) u_snap (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_vld    (c_vld[TICK_BITS]),
    .in_rs     (c_rs[TICK_BITS]),
    .in_re     (c_re[TICK_BITS]),
    .in_cs     (c_cs[TICK_BITS]),
    .in_ce     (c_ce[TICK_BITS]),
    .in_listed (c_listed[TICK_BITS]),
    .in_rem_s  (c_rem_s[TICK_BITS]),
    .in_rem_e  (c_rem_e[TICK_BITS]),
    .out_vld   (done),
    .out_start (new_start),
    .out_end   (new_end),
    .out_moved (moved)
  );

  // every accepted transaction yields a strobe at the end of the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("result strobe missing after fixed latency");

  // moved flag only rides on a result
  a_moved_done: assert property (@(posedge clk) disable iff (rst)
    moved |-> done)
    else $error("moved flag without result strobe");

  // in quantize or fixed-length mode a moved note has end after start
  a_end_after: assert property (@(posedge clk) disable iff (rst)
    (done && moved && (quantize_enable || fixed_length_enable)) |-> (new_end > new_start))
    else $error("moved note with end not after start");

endmodule
`default_nettype wire

>>> hdl/ngq_div_stage.sv
`default_nettype none
module ngq_div_stage #(
  parameter int TICK_BITS = 32,
  parameter int BIT_POS   = 31
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ngq_pkg::GRID_BITS-1:0] grid,
  input  wire logic                          in_vld,
  input  wire logic [TICK_BITS-1:0]          in_rs,
  input  wire logic [TICK_BITS-1:0]          in_re,
  input  wire logic [TICK_BITS-1:0]          in_cs,
  input  wire logic [TICK_BITS-1:0]          in_ce,
  input  wire logic                          in_listed,
  input  wire logic [ngq_pkg::GRID_BITS-1:0] in_rem_s,
  input  wire logic [ngq_pkg::GRID_BITS-1:0] in_rem_e,
  output logic                               out_vld,
  output logic [TICK_BITS-1:0]               out_rs,
  output logic [TICK_BITS-1:0]               out_re,
  output logic [TICK_BITS-1:0]               out_cs,
  output logic [TICK_BITS-1:0]               out_ce,
  output logic                               out_listed,
  output logic [ngq_pkg::GRID_BITS-1:0]      out_rem_s,
  output logic [ngq_pkg::GRID_BITS-1:0]      out_rem_e
);
  import ngq_pkg::*;

  logic [GRID_BITS:0]   trial_s;
  logic [GRID_BITS:0]   trial_e;
  logic [GRID_BITS-1:0] rem_s_next;
  logic [GRID_BITS-1:0] rem_e_next;

  // one restoring step per lane: shift in a dividend bit, subtract if it fits
  always_comb begin
    trial_s = {in_rem_s, in_rs[BIT_POS]};
    trial_e = {in_rem_e, in_re[BIT_POS]};
    if (trial_s >= {1'b0, grid}) begin
      rem_s_next = GRID_BITS'(trial_s - {1'b0, grid});
    end else begin
      rem_s_next = trial_s[GRID_BITS-1:0];
    end
    if (trial_e >= {1'b0, grid}) begin
      rem_e_next = GRID_BITS'(trial_e - {1'b0, grid});
    end else begin
      rem_e_next = trial_e[GRID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
    out_rs     <= in_rs;
    out_re     <= in_re;
    out_cs     <= in_cs;
    out_ce     <= in_ce;
    out_listed <= in_listed;
    out_rem_s  <= rem_s_next;
    out_rem_e  <= rem_e_next;
  end

endmodule
`default_nettype wire

>>> hdl/ngq_snap.sv
`default_nettype none
module ngq_snap #(
  parameter int TICK_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ngq_pkg::ngq_cfg_t             cfg,
  input  wire logic                          in_vld,
  input  wire logic [TICK_BITS-1:0]          in_rs,
  input  wire logic [TICK_BITS-1:0]          in_re,
  input  wire logic [TICK_BITS-1:0]          in_cs,
  input  wire logic [TICK_BITS-1:0]          in_ce,
  input  wire logic                          in_listed,
  input  wire logic [ngq_pkg::GRID_BITS-1:0] in_rem_s,
  input  wire logic [ngq_pkg::GRID_BITS-1:0] in_rem_e,
  output logic                               out_vld,
  output logic [TICK_BITS:0]                 out_start,
  output logic [TICK_BITS:0]                 out_end,
  output logic                               out_moved
);
  import ngq_pkg::*;

  // stage a: start (snapped, recorded or current), grid end, recorded length
  logic [TICK_BITS-1:0] lo;
  logic [TICK_BITS:0]   hi;
  logic [TICK_BITS:0]   snap;
  logic [TICK_BITS:0]   q_next;
  logic [TICK_BITS:0]   eg_next;
  logic [TICK_BITS-1:0] ld_next;
  logic [GRID_BITS:0]   rem2;

  logic                 a_vld;
  logic [TICK_BITS:0]   a_q;
  logic [TICK_BITS:0]   a_eg;
  logic [TICK_BITS-1:0] a_ld;
  logic [TICK_BITS-1:0] a_rs;
  logic [TICK_BITS-1:0] a_re;
  logic [TICK_BITS-1:0] a_cs;
  logic [TICK_BITS-1:0] a_ce;
  logic                 a_listed;
  logic                 a_mode;

  always_comb begin
    lo   = in_rs - TICK_BITS'(in_rem_s);
    hi   = {1'b0, lo} + (TICK_BITS+1)'(cfg.grid);
    rem2 = {in_rem_s, 1'b0};
    if (cfg.capture) begin
      if ({1'b0, in_rem_s} >= {1'b0, cfg.grid} - {1'b0, cfg.win}) begin
        snap = hi;
      end else if (in_rem_s <= cfg.win) begin
        snap = {1'b0, lo};
      end else begin
        snap = {1'b0, in_rs};
      end
    end else if (rem2 <= {1'b0, cfg.grid}) begin
      snap = {1'b0, lo};  // tie goes to the earlier line
    end else begin
      snap = hi;
    end
    if (!cfg.start_en) begin
      q_next = {1'b0, in_cs};
    end else if (cfg.quant) begin
      q_next = snap;
    end else begin
      q_next = {1'b0, in_rs};
    end
    eg_next = {1'b0, in_re - TICK_BITS'(in_rem_e)} + (TICK_BITS+1)'(cfg.grid);
    if (in_re > in_rs) begin
      ld_next = in_re - in_rs;
    end else begin
      ld_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_vld;
    end
    a_q      <= q_next;
    a_eg     <= eg_next;
    a_ld     <= ld_next;
    a_rs     <= in_rs;
    a_re     <= in_re;
    a_cs     <= in_cs;
    a_ce     <= in_ce;
    a_listed <= in_listed;
    a_mode   <= cfg.quant | cfg.fixed_en;
  end

  // stage b: end with saturation and minimum length
  logic [TICK_BITS+1:0] e_raw;
  logic [TICK_BITS:0]   e_sat;
  logic [TICK_BITS:0]   e_next;

  logic                 b_vld;
  logic [TICK_BITS:0]   b_q;
  logic [TICK_BITS:0]   b_e;
  logic [TICK_BITS-1:0] b_rs;
  logic [TICK_BITS-1:0] b_re;
  logic [TICK_BITS-1:0] b_cs;
  logic [TICK_BITS-1:0] b_ce;
  logic                 b_listed;
  logic                 b_mode;

  always_comb begin
    if (cfg.fixed_en) begin
      e_raw = {1'b0, a_q} + (TICK_BITS+2)'(cfg.fixed_len);
    end else if (cfg.end_en) begin
      e_raw = {1'b0, a_eg};
    end else begin
      e_raw = {1'b0, a_q} + (TICK_BITS+2)'(a_ld);
    end
    if (e_raw[TICK_BITS+1]) begin
      e_sat = '1;
    end else begin
      e_sat = e_raw[TICK_BITS:0];
    end
    if (e_sat <= a_q) begin
      e_next = a_q + (TICK_BITS+1)'(1);
    end else begin
      e_next = e_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_q      <= a_q;
    b_e      <= e_next;
    b_rs     <= a_rs;
    b_re     <= a_re;
    b_cs     <= a_cs;
    b_ce     <= a_ce;
    b_listed <= a_listed;
    b_mode   <= a_mode;
  end

  // stage c: move decision
  logic               moved_next;
  logic [TICK_BITS:0] ns_next;
  logic [TICK_BITS:0] ne_next;

  always_comb begin
    ns_next = {1'b0, b_cs};
    ne_next = {1'b0, b_ce};
    if (b_mode) begin
      moved_next = b_listed && (({1'b0, b_cs} != b_q) || ({1'b0, b_ce} != b_e));
      if (moved_next) begin
        ns_next = b_q;
        ne_next = b_e;
      end
    end else begin
      moved_next = b_listed && ((b_rs != b_cs) || (b_re != b_ce));
      if (moved_next) begin
        ns_next = {1'b0, b_rs};
        ne_next = {1'b0, b_re};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld   <= 1'b0;
      out_moved <= 1'b0;
    end else begin
      out_vld   <= b_vld;
      out_moved <= b_vld & moved_next;
    end
    out_start <= ns_next;
    out_end   <= ne_next;
  end

endmodule
`default_nettype wire
